### design/bmp24_stream_to_pixel_writes_core_assert.svh
// ----------------------------------------------------------------------------
// BMP24 decoder assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_TO_PIXEL_WRITES_CORE_ASSERT_SVH
`define BMP24_STREAM_TO_PIXEL_WRITES_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold too.
`define BMP24_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bmp24 check failed: same-cycle implication");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define BMP24_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bmp24 check failed: next-cycle implication");
`else
`define BMP24_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMP24_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/bmp24_pkg.sv
// ----------------------------------------------------------------------------
// BMP24 decoder package
// Field widths shared by the decoder files; result codes and the core's result word.
// ----------------------------------------------------------------------------
package bmp24_pkg;

	localparam int MAX_DIM  = 512;
	localparam int DIM_W    = 10;
	localparam int COORD_W  = 9;
	localparam int ADDR_W   = 18;
	localparam int COLOR_W  = 24;
	localparam int KIND_W   = 3;
	localparam int PLOG_W   = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_PIXEL     = 3'd0,
		KIND_HEADER_OK = 3'd1,
		KIND_BAD_SIG   = 3'd2,
		KIND_BAD_DEPTH = 3'd3,
		KIND_TOO_LARGE = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [DIM_W-1:0]   row_pitch;
		logic               last;
	} result_t;

endpackage

### design/bmp24_in_if.sv
// ----------------------------------------------------------------------------
// BMP24 byte channel
// Valid/ready channel carrying one file byte and its start-of-file flag.
// ----------------------------------------------------------------------------
interface bmp24_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       first_byte;

	modport source(output valid, output file_byte, output first_byte, input ready);
	modport sink(input valid, input file_byte, input first_byte, output ready);
endinterface

### design/bmp24_out_if.sv
// ----------------------------------------------------------------------------
// BMP24 result channel
// Valid/ready channel carrying pixel writes and header status words.
// ----------------------------------------------------------------------------
interface bmp24_out_if;
	import bmp24_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic [DIM_W-1:0]   image_width;
	logic [DIM_W-1:0]   image_height;
	logic [DIM_W-1:0]   row_pitch;
	logic               last;

	modport source(output valid, output kind, output pixel_address, output pixel_color,
		output image_width, output image_height, output row_pitch, output last,
		input ready);
	modport sink(input valid, input kind, input pixel_address, input pixel_color,
		input image_width, input image_height, input row_pitch, input last,
		output ready);
endinterface

### design/bmp24_stream_to_pixel_writes_core.sv
// ----------------------------------------------------------------------------
// BMP24 stream to pixel writes
// Parses a 24-bit bitmap file byte by byte and issues framebuffer writes.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  bytes     in         file_byte, first_byte
//  writes    out        kind, pixel_address, pixel_color, image_width,
//                       image_height, row_pitch, last
//
// One byte is taken per clock; its result, if any, is registered and shown
// on the next cycle. The single output register sets the rate: a new byte is
// taken whenever that register is empty or being drained in the same cycle.
// A stall on writes holds the result and stops bytes; reset (arst_n low)
// clears the parser to idle and empties the output register.
`include "bmp24_stream_to_pixel_writes_core_assert.svh"

module bmp24_stream_to_pixel_writes_core (
	input logic clk,
	input logic arst_n,
	bmp24_in_if.sink bytes,
	bmp24_out_if.source writes
);
	import bmp24_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_PIXEL  = 4'b0100,
		PH_PAD    = 4'b1000
	} phase_t;

	localparam logic [5:0]  POS_SIG    = 6'd1;
	localparam logic [5:0]  POS_WIDTH  = 6'd21;
	localparam logic [5:0]  POS_HEIGHT = 6'd25;
	localparam logic [5:0]  POS_DEPTH  = 6'd29;
	localparam logic [5:0]  POS_LAST   = 6'd53;
	localparam logic [15:0] SIGNATURE  = 16'h4D42;
	localparam logic [15:0] DEPTH_24   = 16'd24;

	phase_t              phase_q, phase_d, phase_cur;
	logic [5:0]          pos_q, pos_d, pos_cur;
	logic [31:0]         fa_q, fa_d, fa_cur;
	logic [DIM_W-1:0]    width_q, width_d;
	logic [DIM_W-1:0]    height_q, height_d;
	logic                big_w_q, big_w_d, big_h_q, big_h_d;
	logic [PLOG_W-1:0]   plog_q, plog_d;
	logic [COORD_W-1:0]  column_q, column_d;
	logic [COORD_W-1:0]  row_q, row_d;
	logic [1:0]          bip_q, bip_d;
	logic [15:0]         hold_q, hold_d;
	logic [1:0]          pad_q, pad_d;

	logic                emit;
	result_t             res_d, res_q;
	logic                out_valid_q;
	logic                in_acc;
	logic [DIM_W-1:0]    pitch;
	logic [DIM_W-1:0]    col_inc;
	logic                final_px;
	logic                empty;

	// Smallest exponent whose power of two covers the width; zero width gives 0.
	function automatic logic [PLOG_W-1:0] ceil_log2(input logic [DIM_W-1:0] w);
		logic [DIM_W-1:0]  x;
		logic [PLOG_W-1:0] r;
		x = w - DIM_W'(1);
		r = '0;
		if (w > DIM_W'(1)) begin
			for (int i = 0; i < DIM_W; i++) begin
				if (x[i])
					r = PLOG_W'(i + 1);
			end
		end
		return r;
	endfunction

	assign bytes.ready = !out_valid_q || writes.ready;
	assign in_acc      = bytes.valid && bytes.ready;

	assign phase_cur = bytes.first_byte ? PH_HEADER : phase_q;
	assign pos_cur   = bytes.first_byte ? 6'd0 : pos_q;
	assign fa_cur    = bytes.first_byte ? 32'd0 : fa_q;

	assign pitch    = DIM_W'(1) << plog_q;
	assign col_inc  = DIM_W'(column_q) + DIM_W'(1);
	assign final_px = (col_inc == width_q) && (row_q == '0);
	assign empty    = (width_q == '0) || (height_q == '0);

	always_comb begin
		phase_d  = phase_cur;
		pos_d    = pos_cur;
		fa_d     = fa_cur;
		width_d  = width_q;
		height_d = height_q;
		big_w_d  = big_w_q;
		big_h_d  = big_h_q;
		plog_d   = plog_q;
		column_d = column_q;
		row_d    = row_q;
		bip_d    = bip_q;
		hold_d   = hold_q;
		pad_d    = pad_q;
		emit     = 1'b0;
		res_d    = '0;

		unique case (phase_cur)
			PH_HEADER: begin
				fa_d  = {bytes.file_byte, fa_cur[31:8]};
				pos_d = pos_cur + 6'd1;
				unique case (pos_cur)
					POS_SIG: begin
						if (fa_d[31:16] != SIGNATURE) begin
							phase_d    = PH_IDLE;
							emit       = 1'b1;
							res_d.kind = KIND_BAD_SIG;
						end
					end
					POS_WIDTH: begin
						width_d = fa_d[DIM_W-1:0];
						big_w_d = fa_d > 32'(MAX_DIM);
					end
					POS_HEIGHT: begin
						height_d = fa_d[DIM_W-1:0];
						big_h_d  = fa_d > 32'(MAX_DIM);
					end
					POS_DEPTH: begin
						priority if (fa_d[31:16] != DEPTH_24) begin
							phase_d    = PH_IDLE;
							emit       = 1'b1;
							res_d.kind = KIND_BAD_DEPTH;
						end else if (big_w_q || big_h_q) begin
							phase_d    = PH_IDLE;
							emit       = 1'b1;
							res_d.kind = KIND_TOO_LARGE;
						end else begin
							plog_d = ceil_log2(width_q);
						end
					end
					POS_LAST: begin
						column_d           = '0;
						row_d              = empty ? '0 : COORD_W'(height_q - DIM_W'(1));
						bip_d              = '0;
						pad_d              = '0;
						phase_d            = empty ? PH_IDLE : PH_PIXEL;
						emit               = 1'b1;
						res_d.kind         = KIND_HEADER_OK;
						res_d.image_width  = width_q;
						res_d.image_height = height_q;
						res_d.row_pitch    = pitch;
						res_d.last         = empty;
					end
					default: begin
					end
				endcase
			end
			PH_PIXEL: begin
				unique case (bip_q)
					2'd0: begin
						hold_d = {8'd0, bytes.file_byte};
						bip_d  = 2'd1;
					end
					2'd1: begin
						hold_d = {bytes.file_byte, hold_q[7:0]};
						bip_d  = 2'd2;
					end
					default: begin
						bip_d               = '0;
						emit                = 1'b1;
						res_d.kind          = KIND_PIXEL;
						res_d.pixel_address = ADDR_W'(column_q) + (ADDR_W'(row_q) << plog_q);
						res_d.pixel_color   = {hold_q[7:0], hold_q[15:8], bytes.file_byte};
						res_d.image_width   = width_q;
						res_d.image_height  = height_q;
						res_d.row_pitch     = pitch;
						res_d.last          = final_px;
						if (final_px) begin
							phase_d = PH_IDLE;
						end else if (col_inc >= width_q) begin
							// End of row: skip the padding bytes, if any.
							pad_d = width_q[1:0];
							if (width_q[1:0] != 2'd0) begin
								phase_d = PH_PAD;
							end else begin
								row_d    = row_q - COORD_W'(1);
								column_d = '0;
							end
						end else begin
							column_d = col_inc[COORD_W-1:0];
						end
					end
				endcase
			end
			PH_PAD: begin
				pad_d = pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					phase_d  = PH_PIXEL;
					row_d    = row_q - COORD_W'(1);
					column_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			fa_q     <= '0;
			width_q  <= '0;
			height_q <= '0;
			big_w_q  <= 1'b0;
			big_h_q  <= 1'b0;
			plog_q   <= '0;
			column_q <= '0;
			row_q    <= '0;
			bip_q    <= '0;
			hold_q   <= '0;
			pad_q    <= '0;
		end else if (in_acc) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			fa_q     <= fa_d;
			width_q  <= width_d;
			height_q <= height_d;
			big_w_q  <= big_w_d;
			big_h_q  <= big_h_d;
			plog_q   <= plog_d;
			column_q <= column_d;
			row_q    <= row_d;
			bip_q    <= bip_d;
			hold_q   <= hold_d;
			pad_q    <= pad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= emit;
		end else if (writes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			res_q <= res_d;
		end
	end

	assign writes.valid         = out_valid_q;
	assign writes.kind          = res_q.kind;
	assign writes.pixel_address = res_q.pixel_address;
	assign writes.pixel_color   = res_q.pixel_color;
	assign writes.image_width   = res_q.image_width;
	assign writes.image_height  = res_q.image_height;
	assign writes.row_pitch     = res_q.row_pitch;
	assign writes.last          = res_q.last;

	`BMP24_ASSERT_IMP(a_col_in_row, clk, arst_n, phase_q == PH_PIXEL, DIM_W'(column_q) < width_q)
	`BMP24_ASSERT_IMP(a_pad_nonzero, clk, arst_n, phase_q == PH_PAD, pad_q != 2'd0)
	`BMP24_ASSERT_IMP(a_bip_range, clk, arst_n, 1'b1, bip_q != 2'd3)
	`BMP24_ASSERT_NXT(a_pixel_emits, clk, arst_n, in_acc && !bytes.first_byte && phase_q == PH_PIXEL && bip_q == 2'd2, out_valid_q && writes.kind == KIND_PIXEL)

endmodule
